// ===== rtl/assert_macros.svh =====
// assertion macros used by the ir code detector core
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// when cond holds, result must hold in the next clock cycle
`define ASSERT_NEXT(label, clk, rstn, cond, result) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (result)) \
        else $error("assertion failed");

`endif

// ===== rtl/ircd_pkg.sv =====
// types, constants and helpers of the ir remote code detector
// no dependencies; imported by every module of the block
package ircd_pkg;

    // receiver phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEAD_LOW,
        PH_LEAD_HIGH,
        PH_BITS
    } phase_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_HIGH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN    = 2'd3;
    localparam int CFG_DATA_W = 32;

    // register reset values
    localparam logic [31:0] MATCH_CODE_RST = 32'h10EF_D827;
    localparam logic [7:0]  LEAD_LOW_RST   = 8'd90;
    localparam logic [7:0]  LEAD_HIGH_RST  = 8'd35;
    localparam logic [7:0]  ONE_MIN_RST    = 8'd12;

    localparam int CODE_W = 32;
    localparam int TICK_W = 8;

    // configuration seen by the decoder
    typedef struct packed {
        logic [CODE_W-1:0] match_code;
        logic [TICK_W-1:0] lead_low_ticks;
        logic [TICK_W-1:0] lead_high_ticks;
        logic [TICK_W-1:0] one_min_ticks;
    } cfg_t;

    // result of one sample
    typedef struct packed {
        logic              frame_done;
        logic              code_match;
        logic [CODE_W-1:0] received_code;
    } result_t;

    // tick counter increment that stops at all ones
    function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
        sat_inc = (v == {TICK_W{1'b1}}) ? v : v + TICK_W'(1);
    endfunction

endpackage

// ===== rtl/ircd_cfg.sv =====
// configuration registers of the ir remote code detector
// depends on ircd_pkg
module ircd_cfg
    import ircd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MATCH_CODE: cfg_next.match_code      = cfg_wdata[CODE_W-1:0];
                CFG_LEAD_LOW:   cfg_next.lead_low_ticks  = cfg_wdata[TICK_W-1:0];
                CFG_LEAD_HIGH:  cfg_next.lead_high_ticks = cfg_wdata[TICK_W-1:0];
                CFG_ONE_MIN:    cfg_next.one_min_ticks   = cfg_wdata[TICK_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.match_code      <= MATCH_CODE_RST;
            cfg_reg.lead_low_ticks  <= LEAD_LOW_RST;
            cfg_reg.lead_high_ticks <= LEAD_HIGH_RST;
            cfg_reg.one_min_ticks   <= ONE_MIN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/ircd_core.sv =====
// leader detection, space timing and word assembly for one line sample
// depends on ircd_pkg and assert_macros.svh
`include "assert_macros.svh"

module ircd_core
    import ircd_pkg::*;
#(
    parameter int FRAME_BITS = 32
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  logic    ir_level,
    input  cfg_t    cfg,
    output result_t result
);

    localparam int BI_W = $clog2(FRAME_BITS);

    phase_t                phase_reg, phase_next, phase_lead;
    logic [TICK_W-1:0]     phase_ticks_reg, phase_ticks_next;
    logic [TICK_W-1:0]     space_ticks_reg, space_ticks_next, space_ticks_lead;
    logic                  space_seen_reg, space_seen_next;
    logic [BI_W-1:0]       bit_index_reg, bit_index_next;
    logic [FRAME_BITS-1:0] shift_word_reg, shift_word_next, shift_word_new;
    logic [TICK_W-1:0]     ticks_inc;
    logic                  bit_end;
    logic                  frame_end;
    logic [CODE_W-1:0]     word;

    assign ticks_inc = sat_inc(phase_ticks_reg);

    // leader phase step, before bit reception
    always_comb begin
        phase_lead = phase_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (!ir_level) phase_lead = PH_LEAD_LOW;
            end
            PH_LEAD_LOW: begin
                if (ticks_inc > cfg.lead_low_ticks)
                    phase_lead = ir_level ? PH_LEAD_HIGH : PH_IDLE;
            end
            PH_LEAD_HIGH: begin
                if (ticks_inc > cfg.lead_high_ticks)
                    phase_lead = ir_level ? PH_IDLE : PH_BITS;
            end
            PH_BITS: phase_lead = PH_BITS;
            default: phase_lead = PH_IDLE;
        endcase
    end

    // a low sample closes an open space; the last bit ends the frame
    assign bit_end   = (phase_lead == PH_BITS) && !ir_level && space_seen_reg;
    assign frame_end = bit_end && (bit_index_reg == BI_W'(FRAME_BITS - 1));

    // next phase
    always_comb begin
        phase_next = frame_end ? PH_IDLE : phase_lead;
    end

    // counters, shift word and result
    always_comb begin
        phase_ticks_next = ticks_inc;
        space_ticks_lead = space_ticks_reg;
        if (phase_reg == PH_IDLE && !ir_level) begin
            phase_ticks_next = '0;
        end else if (phase_reg == PH_LEAD_LOW && phase_lead == PH_LEAD_HIGH) begin
            phase_ticks_next = '0;
        end else if (phase_reg == PH_LEAD_HIGH && phase_lead == PH_BITS) begin
            space_ticks_lead = '0;
        end

        space_ticks_next = space_ticks_lead;
        space_seen_next  = space_seen_reg;
        bit_index_next   = bit_index_reg;
        shift_word_new   = {shift_word_reg[FRAME_BITS-2:0],
                            (space_ticks_lead >= cfg.one_min_ticks)};
        shift_word_next  = shift_word_reg;
        if (phase_lead == PH_BITS && ir_level) begin
            space_ticks_next = sat_inc(space_ticks_lead);
            space_seen_next  = 1'b1;
        end else if (bit_end) begin
            space_seen_next  = 1'b0;
            space_ticks_next = '0;
            shift_word_next  = shift_word_new;
            bit_index_next   = bit_index_reg + BI_W'(1);
        end

        word = CODE_W'(shift_word_new);
        result.frame_done    = 1'b0;
        result.code_match    = 1'b0;
        result.received_code = '0;
        if (frame_end) begin
            result.frame_done    = 1'b1;
            result.code_match    = (word == cfg.match_code);
            result.received_code = word;
            shift_word_next      = '0;
            bit_index_next       = '0;
        end
    end

    // state registers, updated once per accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            phase_ticks_reg <= '0;
            space_ticks_reg <= '0;
            space_seen_reg  <= 1'b0;
            bit_index_reg   <= '0;
            shift_word_reg  <= '0;
        end else if (step_en) begin
            phase_reg       <= phase_next;
            phase_ticks_reg <= phase_ticks_next;
            space_ticks_reg <= space_ticks_next;
            space_seen_reg  <= space_seen_next;
            bit_index_reg   <= bit_index_next;
            shift_word_reg  <= shift_word_next;
        end
    end

    // a completed frame leaves the receiver idle with an empty bit count
    `ASSERT_NEXT(a_frame_end_idle, aclk, aresetn, step_en && result.frame_done, phase_reg == PH_IDLE && bit_index_reg == '0)
    // no space is open outside bit reception
    `ASSERT_ALWAYS(a_space_only_in_bits, aclk, aresetn, phase_reg == PH_BITS || !space_seen_reg)
    // bits are only counted while receiving
    `ASSERT_ALWAYS(a_bits_only_in_bits, aclk, aresetn, phase_reg == PH_BITS || bit_index_reg == '0)

endmodule

// ===== rtl/ir_remote_code_detector.sv =====
// top level of the ir remote code detector: stream ports and result register
// depends on ircd_pkg, ircd_cfg and ircd_core
//
// One input item is one sample of the demodulated IR line (a 0.1 ms tick);
// every accepted item yields exactly one result item. A frame is a long low
// leader, a high gap, then FRAME_BITS pulse-distance bits whose high spaces
// are timed against one_min_ticks; on the sample that closes the last space
// the result carries frame_done, the assembled word (first bit in the MSB)
// and its comparison with match_code. The block takes one item per clock
// while the result register is empty or being drained, and a result appears
// in the cycle after its item is taken: the whole decode step is one update
// of the receiver state, followed by a single output register. A new item is
// taken in the same clock as the previous result is taken; while a result
// waits, s_tready stays low. Write configuration only while no item is in flight.
module ir_remote_code_detector
    import ircd_pkg::*;
#(
    parameter int FRAME_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // line samples
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] ir_level, [7:1] zero
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [CODE_W-1:0]     m_tdata,   // [31:0] received_code
    output logic [1:0]            m_tuser    // [0] frame_done, [1] code_match
);

    cfg_t    cfg;
    result_t result;
    result_t result_reg;
    logic    m_valid_reg, m_valid_next;
    logic    step_en;

    ircd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // accept while the result register is empty or being drained
    assign s_tready = !m_valid_reg || m_tready;
    assign step_en  = s_tvalid && s_tready;

    ircd_core #(
        .FRAME_BITS (FRAME_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step_en),
        .ir_level (s_tdata[0]),
        .cfg      (cfg),
        .result   (result)
    );

    // result register valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (step_en)       m_valid_next = 1'b1;
        else if (m_tready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (step_en) result_reg <= result;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = result_reg.received_code;
    assign m_tuser  = {result_reg.code_match, result_reg.frame_done};

endmodule

// ===== tb/ir_remote_code_detector_tb.sv =====
// testbench of ir_remote_code_detector: ir line samples in, one checked result per sample
// depends on ircd_pkg and the ir_remote_code_detector rtl; self-checking, no external files
`timescale 1ns / 1ps

module ir_remote_code_detector_tb;
    import ircd_pkg::*;

    localparam int FRAME_BITS  = 32;
    localparam int CLK_HALF    = 5;
    localparam int HOLD_CYCLES = 64;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 8;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;     // [0] ir_level, [7:1] zero
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [CODE_W-1:0]     m_tdata;          // [31:0] received_code
    logic [1:0]            m_tuser;          // [0] frame_done, [1] code_match

    // decoder state as the checker sees it
    logic [CODE_W-1:0]     cfg_match     = MATCH_CODE_RST;
    logic [TICK_W-1:0]     cfg_lead_low  = LEAD_LOW_RST;
    logic [TICK_W-1:0]     cfg_lead_high = LEAD_HIGH_RST;
    logic [TICK_W-1:0]     cfg_one_min   = ONE_MIN_RST;
    phase_t                line_phase    = PH_IDLE;
    logic [TICK_W-1:0]     lead_ticks    = '0;
    logic [TICK_W-1:0]     space_len     = '0;
    logic                  space_open    = 1'b0;
    logic [5:0]            bits_taken    = '0;
    logic [63:0]           code_shift    = '0;

    // traffic control
    logic                  line_samples[$];
    result_t               expected_results[$];
    int                    tx_idle_pct = 23;
    int                    rx_idle_pct = 51;
    logic                  tx_pause = 1'b0;
    int                    hold_reqs = 0;
    int                    hold_served = 0;
    int                    hold_left = 0;
    logic                  s_took = 1'b0;
    logic                  m_took = 1'b0;
    int                    mismatch_count = 0;

    ir_remote_code_detector #(
        .FRAME_BITS(FRAME_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #CLK_HALF aclk = ~aclk;

    // one tick of the decoder: advance state, return the result of this sample
    function automatic result_t decode_sample(input logic level);
        result_t r;
        logic [31:0] word;
        r = '0;
        if (lead_ticks != '1) lead_ticks = lead_ticks + 1'b1;

        if (line_phase == PH_IDLE && !level) begin
            lead_ticks = '0;
            line_phase = PH_LEAD_LOW;
        end else if (line_phase == PH_LEAD_LOW && lead_ticks > cfg_lead_low) begin
            if (level) begin
                line_phase = PH_LEAD_HIGH;
                lead_ticks = '0;
            end else begin
                line_phase = PH_IDLE;
            end
        end else if (line_phase == PH_LEAD_HIGH && lead_ticks > cfg_lead_high) begin
            if (!level) begin
                space_len  = '0;
                line_phase = PH_BITS;
            end else begin
                line_phase = PH_IDLE;
            end
        end

        // time the high space, the next low closes it into one bit
        if (line_phase == PH_BITS && level) begin
            if (space_len != '1) space_len = space_len + 1'b1;
            space_open = 1'b1;
        end else if (line_phase == PH_BITS && space_open) begin
            space_open = 1'b0;
            code_shift = {code_shift[62:0], space_len >= cfg_one_min};
            space_len  = '0;
            bits_taken = bits_taken + 1'b1;
        end

        if (bits_taken >= FRAME_BITS) begin
            word            = code_shift[31:0];
            r.frame_done    = 1'b1;
            r.code_match    = (word == cfg_match);
            r.received_code = word;
            code_shift      = '0;
            bits_taken      = '0;
            line_phase      = PH_IDLE;
        end
        return r;
    endfunction

    // sender: next sample goes out at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (line_samples.size() != 0 && !tx_pause && $urandom_range(0, 99) >= tx_idle_pct) begin
                s_tdata  <= {7'd0, line_samples.pop_front()};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_reqs) begin
            hold_served <= hold_reqs;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // handshakes at the rising edge: predict on input, check on output
    always @(posedge aclk) begin
        result_t want;
        s_took = aresetn && s_tvalid && s_tready;
        m_took = aresetn && m_tvalid && m_tready;
        if (s_took) expected_results.push_back(decode_sample(s_tdata[0]));
        if (m_took) begin
            if (expected_results.size() == 0) begin
                $error("result with no sample pending: tuser %b tdata %h", m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tuser[0] !== want.frame_done) begin
                    $error("frame_done: expected %0d, got %0d", want.frame_done, m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tuser[1] !== want.code_match) begin
                    $error("code_match: expected %0d, got %0d", want.code_match, m_tuser[1]);
                    mismatch_count++;
                end
                if (m_tdata !== want.received_code) begin
                    $error("received_code: expected %h, got %h", want.received_code, m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(negedge aclk);
            if (s_took || m_took) quiet = 0;
            else quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic add_samples(input logic level, input int n);
        repeat (n) line_samples.push_back(level);
    endtask

    // leader from idle; nonzero adjustments shift the low or high length by one
    task automatic add_leader(input int low_adj, input int high_adj);
        int lows;
        int highs;
        lows  = int'(cfg_lead_low) + 1 + low_adj;
        highs = int'(cfg_lead_high) + 1 + high_adj;
        add_samples(1'b1, $urandom_range(1, 3));
        add_samples(1'b0, (lows < 1) ? 1 : lows);
        add_samples(1'b1, (highs < 1) ? 1 : highs);
        add_samples(1'b0, 1);
    endtask

    // pulse-distance bits, msb first, spaces near the one/zero boundary now and then
    task automatic add_bits(input logic [31:0] code);
        int om;
        int h;
        om = int'(cfg_one_min);
        for (int i = 31; i >= 0; i--) begin
            if (code[i]) h = (om >= 250) ? 256 + $urandom_range(0, 4) : om + $urandom_range(0, 3);
            else if (om <= 1) h = 1;
            else if (om <= 16 && $urandom_range(0, 3) == 0) h = om - 1;
            else h = $urandom_range(1, (om > 4) ? 3 : om - 1);
            if (h < 1) h = 1;
            add_samples(1'b1, h);
            add_samples(1'b0, ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1);
        end
    endtask

    function automatic logic [31:0] pick_code();
        case ($urandom_range(0, 5))
            0: return cfg_match;
            1: return cfg_match ^ (32'h1 << $urandom_range(0, 31));
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // mostly clean frames, some line noise and leaders off by one tick
    task automatic add_traffic(input int frames);
        int sent;
        int pick;
        int la;
        int ha;
        sent = 0;
        while (sent < frames) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(4, 16)) line_samples.push_back(1'($urandom_range(0, 1)));
            end else if (pick == 1) begin
                do begin
                    la = $urandom_range(0, 2) - 1;
                    ha = $urandom_range(0, 2) - 1;
                end while (la == 0 && ha == 0);
                add_leader(la, ha);
            end else begin
                add_leader(0, 0);
                add_bits(pick_code());
                sent++;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_MATCH_CODE: cfg_match     = val;
            CFG_LEAD_LOW:   cfg_lead_low  = val[TICK_W-1:0];
            CFG_LEAD_HIGH:  cfg_lead_high = val[TICK_W-1:0];
            CFG_ONE_MIN:    cfg_one_min   = val[TICK_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] code, input int lo, input int hi, input int om);
        write_reg(CFG_MATCH_CODE, code);
        write_reg(CFG_LEAD_LOW, lo);
        write_reg(CFG_LEAD_HIGH, hi);
        write_reg(CFG_ONE_MIN, om);
    endtask

    // nothing queued, nothing offered, nothing outstanding
    task automatic wait_idle();
        do begin
            @(posedge aclk);
            #1;
        end while (line_samples.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: short leader timings
        set_config($urandom, 1, 1, 2);
        // leader low still low at its check, then leader high still high at its check
        add_samples(1'b1, 2);
        add_samples(1'b0, 3);
        add_samples(1'b0, 2);
        add_samples(1'b1, 3);
        // clean leader; the low that enters the bit phase opens no bit
        add_leader(0, 0);
        add_bits(cfg_match);
        // long receiver hold-off while samples keep coming
        hold_reqs = hold_reqs + 1;
        wait_idle();

        // lowest thresholds: every space is a one
        set_config(32'h0, 0, 0, 0);
        add_traffic(1);
        wait_idle();

        // saturation: leader low can never pass at 255, then passes at 254
        tx_idle_pct = 51;
        rx_idle_pct = 23;
        set_config(32'h0000_0001, 255, 0, 255);
        add_samples(1'b1, 2);
        add_samples(1'b0, 260);
        wait_idle();
        write_reg(CFG_LEAD_LOW, 254);
        add_samples(1'b1, 1);
        add_samples(1'b0, 1);
        add_bits(cfg_match);
        wait_idle();

        // mid-range thresholds, sender pauses until all results are back
        set_config('1, 3, 2, 4);
        add_traffic(1);
        while (line_samples.size() > 150) begin
            @(posedge aclk);
            #1;
        end
        tx_pause = 1'b1;
        while (s_tvalid || expected_results.size() != 0) begin
            @(posedge aclk);
            #1;
        end
        tx_pause = 1'b0;
        wait_idle();

        // back to the power-on values, no idling
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_config(MATCH_CODE_RST, int'(LEAD_LOW_RST), int'(LEAD_HIGH_RST), int'(ONE_MIN_RST));
        add_leader(0, 0);
        add_bits(cfg_match);
        repeat (12) line_samples.push_back(1'($urandom_range(0, 1)));
        wait_idle();

        repeat (DRAIN_WAIT) @(posedge aclk);
        #1;
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
